FILE: rtl/core/assert_macros.svh
// Assertion helpers, included by spi_eeprom_byte_controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted (active-low reset).
`define SEBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SEBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/sebc_pkg.sv
// ----------------------------------------------------------------------------
// sebc_pkg
// Types and constants of the SPI EEPROM byte controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sebc_pkg;

    // Tick commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // EEPROM instruction codes and status bits
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] WIP_BIT  = 8'h01;
    localparam logic [7:0] MSB_BIT  = 8'h80;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DESELECT    = 2'd1;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_WREN      = 8'b0000_0010,
        PH_WRITE     = 8'b0000_0100,
        PH_POLL      = 8'b0000_1000,
        PH_READ      = 8'b0001_0000,
        PH_GAP_WRITE = 8'b0010_0000,
        PH_GAP_POLL  = 8'b0100_0000,
        PH_GAP_IDLE  = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  op_kind;
        logic [2:0]  byte_index;
        logic [2:0]  bit_index;
        logic        clock_level;
        logic [7:0]  tx_shift;
        logic [7:0]  rx_shift;
        logic [7:0]  held_data;
        logic [7:0]  divider_count;
        logic [7:0]  gap_count;
    } t_ctrl;

    typedef struct packed {
        logic        cs_n;
        logic        sclk;
        logic        mosi;
        logic        busy_res;
        logic        read_valid;
        logic [7:0]  read_data;
        logic        write_done;
        logic        rejected;
    } t_result;

    localparam t_ctrl CTRL_RESET = '{
        phase:         PH_IDLE,
        op_kind:       2'd0,
        byte_index:    3'd0,
        bit_index:     3'd0,
        clock_level:   1'b0,
        tx_shift:      8'd0,
        rx_shift:      8'd0,
        held_data:     8'd0,
        divider_count: 8'd0,
        gap_count:     8'd0
    };

endpackage

FILE: rtl/core/sebc_step.sv
// ----------------------------------------------------------------------------
// sebc_step
// Next-state and line logic for one tick of the serial engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sebc_step
    import sebc_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  t_ctrl                 i_ctrl,
    input  logic [ADDR_BITS-1:0]  i_held_address,
    input  logic [1:0]            i_cmd,
    input  logic [15:0]           i_address,
    input  logic [7:0]            i_write_data,
    input  logic                  i_miso,
    input  logic [7:0]            i_half_period,
    input  logic [7:0]            i_deselect,
    output t_ctrl                 o_ctrl,
    output logic [ADDR_BITS-1:0]  o_held_address,
    output t_result               o_result
);

    localparam int ADDR_BYTES = (ADDR_BITS + 7) / 8;
    localparam int ADDR_PAD   = ADDR_BYTES * 8;

    function automatic logic [3:0] frame_bytes(input t_phase ph);
        logic [3:0] n;
        unique case (ph)
            PH_WREN: n = 4'd1;
            PH_POLL: n = 4'd2;
            default: n = 4'(2 + ADDR_BYTES);
        endcase
        return n;
    endfunction

    function automatic logic [7:0] frame_byte(input t_phase ph, input logic [2:0] k,
                                              input logic [ADDR_BITS-1:0] addr,
                                              input logic [7:0] data);
        logic [ADDR_PAD-1:0] pad;
        logic [7:0]          b;
        pad = ADDR_PAD'(addr);
        b   = 8'd0;
        if (k == 3'd0) begin
            unique case (ph)
                PH_WREN:  b = OP_WREN;
                PH_WRITE: b = OP_WRITE;
                PH_POLL:  b = OP_RDSR;
                default:  b = OP_READ;
            endcase
        end else if (ph != PH_POLL) begin
            if ({1'b0, k} <= 4'(ADDR_BYTES)) begin
                for (int j = 0; j < ADDR_BYTES; j++) begin
                    if (k == 3'(j + 1)) b = pad[8*(ADDR_BYTES-1-j) +: 8];
                end
            end else if (ph == PH_WRITE) begin
                b = data;
            end
        end
        return b;
    endfunction

    function automatic logic in_frame(input t_phase ph);
        return (ph == PH_WREN) || (ph == PH_WRITE) || (ph == PH_POLL) || (ph == PH_READ);
    endfunction

    logic [7:0] w_half;
    logic [7:0] w_gap;
    logic       w_req;
    logic [7:0] w_div;
    logic [7:0] w_gcnt;
    logic [2:0] w_next_byte;
    logic       w_frame;

    assign w_half = (i_half_period == 8'd0) ? 8'd1 : i_half_period;
    assign w_gap  = (i_deselect == 8'd0) ? 8'd1 : i_deselect;
    assign w_req  = (i_cmd == CMD_READ) || (i_cmd == CMD_WRITE);
    assign w_div  = i_ctrl.divider_count + 8'd1;
    assign w_gcnt = i_ctrl.gap_count + 8'd1;
    assign w_next_byte = i_ctrl.byte_index + 3'd1;

    always_comb begin
        o_ctrl           = i_ctrl;
        o_held_address   = i_held_address;
        o_result         = '0;
        if (w_req && (i_ctrl.phase == PH_IDLE)) begin
            // Latch the request and open its first frame on this tick
            o_held_address     = ADDR_BITS'({8'd0, i_address});
            o_ctrl.held_data   = i_write_data;
            o_ctrl.op_kind     = i_cmd;
            o_ctrl.phase       = (i_cmd == CMD_READ) ? PH_READ : PH_WREN;
            o_ctrl.byte_index  = 3'd0;
            o_ctrl.bit_index   = 3'd0;
            o_ctrl.clock_level = 1'b0;
            o_ctrl.divider_count = 8'd0;
            o_ctrl.rx_shift    = 8'd0;
            o_ctrl.tx_shift    = (i_cmd == CMD_READ) ? OP_READ : OP_WREN;
        end else begin
            o_result.rejected = w_req;
            if (in_frame(i_ctrl.phase)) begin
                o_ctrl.divider_count = w_div;
                if (w_div >= w_half) begin
                    o_ctrl.divider_count = 8'd0;
                    if (!i_ctrl.clock_level) begin
                        // Rising edge: sample MISO
                        o_ctrl.clock_level = 1'b1;
                        o_ctrl.rx_shift    = {i_ctrl.rx_shift[6:0], i_miso};
                    end else begin
                        // Falling edge: advance MOSI
                        o_ctrl.clock_level = 1'b0;
                        o_ctrl.tx_shift    = {i_ctrl.tx_shift[6:0], 1'b0};
                        if (i_ctrl.bit_index == 3'd7) begin
                            o_ctrl.bit_index  = 3'd0;
                            o_ctrl.byte_index = w_next_byte;
                            if ({1'b0, w_next_byte} < frame_bytes(i_ctrl.phase)) begin
                                o_ctrl.tx_shift = frame_byte(i_ctrl.phase, w_next_byte,
                                                             i_held_address,
                                                             i_ctrl.held_data);
                            end else begin
                                unique case (i_ctrl.phase)
                                    PH_WREN:  o_ctrl.phase = PH_GAP_WRITE;
                                    PH_WRITE: o_ctrl.phase = PH_GAP_POLL;
                                    PH_POLL: begin
                                        if ((i_ctrl.rx_shift & WIP_BIT) != 8'd0) begin
                                            o_ctrl.phase = PH_GAP_POLL;
                                        end else begin
                                            o_ctrl.phase = PH_GAP_IDLE;
                                            o_result.write_done = 1'b1;
                                        end
                                    end
                                    default: begin
                                        o_ctrl.phase = PH_GAP_IDLE;
                                        o_result.read_valid = 1'b1;
                                        o_result.read_data  = i_ctrl.rx_shift;
                                    end
                                endcase
                                o_ctrl.gap_count  = 8'd0;
                                o_ctrl.byte_index = 3'd0;
                                o_ctrl.tx_shift   = 8'd0;
                            end
                        end else begin
                            o_ctrl.bit_index = i_ctrl.bit_index + 3'd1;
                        end
                    end
                end
            end else if ((i_ctrl.phase == PH_GAP_WRITE) || (i_ctrl.phase == PH_GAP_POLL) ||
                         (i_ctrl.phase == PH_GAP_IDLE)) begin
                o_ctrl.gap_count = w_gcnt;
                if (w_gcnt >= w_gap) begin
                    o_ctrl.gap_count = 8'd0;
                    if (i_ctrl.phase == PH_GAP_IDLE) begin
                        o_ctrl.phase = PH_IDLE;
                    end else begin
                        o_ctrl.phase = (i_ctrl.phase == PH_GAP_WRITE) ? PH_WRITE : PH_POLL;
                        o_ctrl.byte_index    = 3'd0;
                        o_ctrl.bit_index     = 3'd0;
                        o_ctrl.clock_level   = 1'b0;
                        o_ctrl.divider_count = 8'd0;
                        o_ctrl.rx_shift      = 8'd0;
                        o_ctrl.tx_shift      = (i_ctrl.phase == PH_GAP_WRITE) ? OP_WRITE
                                                                              : OP_RDSR;
                    end
                end
            end else begin
                o_ctrl.phase = PH_IDLE;
            end
        end

        // Line levels after this tick
        w_frame           = in_frame(o_ctrl.phase);
        o_result.cs_n     = !w_frame;
        o_result.sclk     = w_frame && o_ctrl.clock_level;
        o_result.mosi     = w_frame && ((o_ctrl.tx_shift & MSB_BIT) != 8'd0);
        o_result.busy_res = (o_ctrl.phase != PH_IDLE);
    end

endmodule

FILE: rtl/core/spi_eeprom_byte_controller.sv
// ----------------------------------------------------------------------------
// spi_eeprom_byte_controller
// SPI mode 0 master for a 25-series serial EEPROM, one tick per input item.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item is one tick of the serial engine: a command (plain tick,
//   byte read or byte write), the request address and data, and the sampled
//   MISO level. Each item yields exactly one result item with the SPI line
//   levels after that tick and the status flags (busy, read byte ready,
//   write finished, request rejected).
//   A write sends WREN in its own frame, then WRITE with address and data,
//   then polls RDSR until write-in-progress clears. A read sends READ with
//   the address and shifts in one byte. Requests while busy are rejected.
//   The result of an item is loaded into the output register on acceptance.
//   Throughput: one item per cycle while results are taken; the state update
//   is a single pass of the tick logic between state and output registers.
//   The user writes the configuration port (half SCLK period, deselect time)
//   only while no sequence runs, unchecked by the block; it is always ready.
//   Reset (synchronous, active low) returns the engine to idle with chip
//   select high and both timing registers set to one tick.
//   When the receiver stalls, the result is held and the input channel is
//   ready only once the output register can take a new result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spi_eeprom_byte_controller
    import sebc_pkg::*;
#(
    parameter int ADDR_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tick items in
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_cmd,
    input  logic [15:0]          i_address,
    input  logic [7:0]           i_write_data,
    input  logic                 i_miso,
    // result items out
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_cs_n,
    output logic                 o_sclk,
    output logic                 o_mosi,
    output logic                 o_busy_res,
    output logic                 o_read_valid,
    output logic [7:0]           o_read_data,
    output logic                 o_write_done,
    output logic                 o_rejected,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_ctrl                r_ctrl;
    t_ctrl                n_ctrl;
    logic [ADDR_BITS-1:0] r_held_address;
    logic [ADDR_BITS-1:0] n_held_address;
    t_result              r_result;
    t_result              n_result;
    logic                 r_out_valid;
    logic [7:0]           r_half_period;
    logic [7:0]           r_deselect;
    logic                 w_in_accept;

    // Take a new item whenever the output register is free or being drained
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_accept = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    sebc_step #(
        .ADDR_BITS(ADDR_BITS)
    ) u_step (
        .i_ctrl         (r_ctrl),
        .i_held_address (r_held_address),
        .i_cmd          (i_cmd),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_miso         (i_miso),
        .i_half_period  (r_half_period),
        .i_deselect     (r_deselect),
        .o_ctrl         (n_ctrl),
        .o_held_address (n_held_address),
        .o_result       (n_result)
    );

    // Engine state: advance once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl         <= CTRL_RESET;
            r_held_address <= '0;
        end else if (w_in_accept) begin
            r_ctrl         <= n_ctrl;
            r_held_address <= n_held_address;
        end
    end

    // Output register: load on accept, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the idle line levels (chip select high) from reset on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result <= '{cs_n: 1'b1, default: '0};
        end else if (w_in_accept) begin
            r_result <= n_result;
        end
    end

    // Timing registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= 8'd1;
            r_deselect    <= 8'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                CFG_DESELECT:    r_deselect    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cs_n       = r_result.cs_n;
    assign o_sclk       = r_result.sclk;
    assign o_mosi       = r_result.mosi;
    assign o_busy_res   = r_result.busy_res;
    assign o_read_valid = r_result.read_valid;
    assign o_read_data  = r_result.read_data;
    assign o_write_done = r_result.write_done;
    assign o_rejected   = r_result.rejected;

    `SEBC_ASSERT(a_done_excl, i_clk, i_rst_n,
                 o_out_valid |-> !(o_read_valid && o_write_done),
                 "read and write completion flagged together")
    `SEBC_ASSERT(a_cs_busy, i_clk, i_rst_n,
                 (o_out_valid && !o_cs_n) |-> o_busy_res,
                 "chip select low while not busy")
    `SEBC_ASSERT(a_sclk_frame, i_clk, i_rst_n,
                 (o_out_valid && o_sclk) |-> !o_cs_n,
                 "serial clock high outside a frame")
    `SEBC_ASSERT(a_write_start, i_clk, i_rst_n,
                 (w_in_accept && (r_ctrl.phase == PH_IDLE) && (i_cmd == CMD_WRITE))
                     |=> (r_ctrl.phase == PH_WREN),
                 "write request did not open the WREN frame")

endmodule

FILE: test/spi_eeprom_byte_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_eeprom_byte_controller_tb
// Self-checking bench for the SPI EEPROM byte controller. Tick items go in
// through a valid/ready channel and a scoreboard with its own model of the
// serial engine predicts the line levels and flags of every result item.
// Directed read, write and refusal cases come first, then the timing
// extremes, then random request streams under several timing settings, with
// random idling on both channels.
// ----------------------------------------------------------------------------

module spi_eeprom_byte_controller_tb;
    import sebc_pkg::*;

    localparam int ADDR_BITS  = 16;
    localparam int ADDR_BYTES = (ADDR_BITS + 7) / 8;

    // Command code with no meaning of its own: the block takes it as a tick.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Register indexes that select nothing; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {MISO_LOW, MISO_HIGH, MISO_RANDOM} t_miso_mode;

    // ------------------------------------------------------------------------
    // Scoreboard: a tick-accurate model of the serial engine. Each accepted
    // tick item advances the model once and queues the line levels due.
    // ------------------------------------------------------------------------
    class spi_line_scoreboard;
        t_phase      phase;
        logic [1:0]  op_kind;
        logic [2:0]  byte_idx;
        logic [2:0]  bit_idx;
        logic        clk_lvl;
        logic [7:0]  tx_sr;
        logic [7:0]  rx_sr;
        logic [15:0] addr_q;
        logic [7:0]  data_q;
        logic [7:0]  div_cnt;
        logic [7:0]  gap_cnt;
        logic [7:0]  half_reg;
        logic [7:0]  desel_reg;

        t_result     levels_due[$];
        int unsigned errors;
        int unsigned items;
        int unsigned reads_done;
        int unsigned writes_done;
        int unsigned refusals;

        function new();
            phase     = PH_IDLE;
            op_kind   = 2'd0;
            byte_idx  = 3'd0;
            bit_idx   = 3'd0;
            clk_lvl   = 1'b0;
            tx_sr     = 8'd0;
            rx_sr     = 8'd0;
            addr_q    = 16'd0;
            data_q    = 8'd0;
            div_cnt   = 8'd0;
            gap_cnt   = 8'd0;
            half_reg  = 8'd1;
            desel_reg = 8'd1;
            errors    = 0;
            items     = 0;
            reads_done  = 0;
            writes_done = 0;
            refusals    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_HALF_PERIOD: half_reg = val;
                CFG_DESELECT:    desel_reg = val;
                default: ;
            endcase
        endfunction

        function bit is_idle();
            return phase == PH_IDLE;
        endfunction

        function int unsigned pending();
            return levels_due.size();
        endfunction

        function bit in_frame();
            return phase inside {PH_WREN, PH_WRITE, PH_POLL, PH_READ};
        endfunction

        function int unsigned frame_len(t_phase ph);
            if (ph == PH_WREN) return 1;
            if (ph == PH_POLL) return 2;
            return 2 + ADDR_BYTES;
        endfunction

        // Byte k of the frame sent in phase ph: opcode, address MSB first,
        // then the data byte for a write or zero while a byte is read in.
        function logic [7:0] frame_byte(t_phase ph, int unsigned k);
            logic [15:0] shifted;
            if (k == 0) begin
                case (ph)
                    PH_WREN:  return OP_WREN;
                    PH_WRITE: return OP_WRITE;
                    PH_POLL:  return OP_RDSR;
                    default:  return OP_READ;
                endcase
            end
            if (ph == PH_POLL) return 8'd0;
            if (k <= ADDR_BYTES) begin
                shifted = addr_q >> (8 * (ADDR_BYTES - k));
                return shifted[7:0];
            end
            if (ph == PH_WRITE) return data_q;
            return 8'd0;
        endfunction

        function void open_frame(t_phase ph);
            phase    = ph;
            byte_idx = 3'd0;
            bit_idx  = 3'd0;
            clk_lvl  = 1'b0;
            div_cnt  = 8'd0;
            rx_sr    = 8'd0;
            tx_sr    = frame_byte(ph, 0);
        endfunction

        function void note_tick(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data,
                                logic miso);
            t_result    r;
            logic [7:0] half;
            logic [7:0] gap;
            bit         is_req;
            t_phase     next;
            r      = '0;
            half   = (half_reg == 8'd0) ? 8'd1 : half_reg;
            gap    = (desel_reg == 8'd0) ? 8'd1 : desel_reg;
            is_req = (cmd == CMD_READ) || (cmd == CMD_WRITE);
            items++;

            if (is_req && phase == PH_IDLE) begin
                // Take the request and open the first frame on this tick.
                addr_q  = addr;
                data_q  = data;
                op_kind = cmd;
                open_frame(cmd == CMD_READ ? PH_READ : PH_WREN);
            end else begin
                if (is_req) begin
                    r.rejected = 1'b1;
                    refusals++;
                end
                if (in_frame()) begin
                    div_cnt = div_cnt + 8'd1;
                    if (div_cnt >= half) begin
                        div_cnt = 8'd0;
                        if (!clk_lvl) begin
                            // rising edge: sample MISO
                            clk_lvl = 1'b1;
                            rx_sr   = {rx_sr[6:0], miso};
                        end else begin
                            // falling edge: move the next bit onto MOSI
                            clk_lvl = 1'b0;
                            tx_sr   = {tx_sr[6:0], 1'b0};
                            if (bit_idx == 3'd7) begin
                                bit_idx  = 3'd0;
                                byte_idx = byte_idx + 3'd1;
                                if (byte_idx < frame_len(phase)) begin
                                    tx_sr = frame_byte(phase, byte_idx);
                                end else begin
                                    next = PH_GAP_IDLE;
                                    case (phase)
                                        PH_WREN:  next = PH_GAP_WRITE;
                                        PH_WRITE: next = PH_GAP_POLL;
                                        PH_POLL: begin
                                            if ((rx_sr & WIP_BIT) != 8'd0) begin
                                                next = PH_GAP_POLL;
                                            end else begin
                                                r.write_done = 1'b1;
                                                writes_done++;
                                            end
                                        end
                                        default: begin
                                            r.read_valid = 1'b1;
                                            r.read_data  = rx_sr;
                                            reads_done++;
                                        end
                                    endcase
                                    phase    = next;
                                    gap_cnt  = 8'd0;
                                    byte_idx = 3'd0;
                                    tx_sr    = 8'd0;
                                end
                            end else begin
                                bit_idx = bit_idx + 3'd1;
                            end
                        end
                    end
                end else if (phase inside {PH_GAP_WRITE, PH_GAP_POLL, PH_GAP_IDLE}) begin
                    gap_cnt = gap_cnt + 8'd1;
                    if (gap_cnt >= gap) begin
                        gap_cnt = 8'd0;
                        case (phase)
                            PH_GAP_WRITE: open_frame(PH_WRITE);
                            PH_GAP_POLL:  open_frame(PH_POLL);
                            default:      phase = PH_IDLE;
                        endcase
                    end
                end else begin
                    phase = PH_IDLE;
                end
            end

            r.cs_n     = !in_frame();
            r.sclk     = in_frame() ? clk_lvl : 1'b0;
            r.mosi     = in_frame() ? tx_sr[7] : 1'b0;
            r.busy_res = (phase != PH_IDLE);
            levels_due.push_back(r);
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_lines(t_result got);
            t_result want;
            if (levels_due.size() == 0) begin
                $error("result item arrived with nothing expected");
                errors++;
                return;
            end
            want = levels_due.pop_front();
            compare("cs_n",       want.cs_n,       got.cs_n);
            compare("sclk",       want.sclk,       got.sclk);
            compare("mosi",       want.mosi,       got.mosi);
            compare("busy_res",   want.busy_res,   got.busy_res);
            compare("read_valid", want.read_valid, got.read_valid);
            compare("read_data",  want.read_data,  got.read_data);
            compare("write_done", want.write_done, got.write_done);
            compare("rejected",   want.rejected,   got.rejected);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_cmd;
    logic [15:0]          i_address;
    logic [7:0]           i_write_data;
    logic                 i_miso;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_cs_n;
    logic                 o_sclk;
    logic                 o_mosi;
    logic                 o_busy_res;
    logic                 o_read_valid;
    logic [7:0]           o_read_data;
    logic                 o_write_done;
    logic                 o_rejected;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    spi_line_scoreboard sb;

    // When set, neither side idles: back-to-back items in both directions.
    bit steady_run;

    spi_eeprom_byte_controller #(
        .ADDR_BITS (ADDR_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_miso       (i_miso),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cs_n       (o_cs_n),
        .o_sclk       (o_sclk),
        .o_mosi       (o_mosi),
        .o_busy_res   (o_busy_res),
        .o_read_valid (o_read_valid),
        .o_read_data  (o_read_data),
        .o_write_done (o_write_done),
        .o_rejected   (o_rejected),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop well beyond the full run: under a thousand tick items plus
    // the configuration writes and the drains.
    initial begin
        #50_000;
        $display("status: fail");
        $finish;
    end

    // Result side: drop ready with odds of 7 in a hundred, change at the
    // falling edge only.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= steady_run || ($urandom_range(99) >= 7);
        end
    end

    // Sample results at the rising edge; an item moves when valid and ready
    // are both high.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_lines('{cs_n:       o_cs_n,
                             sclk:       o_sclk,
                             mosi:       o_mosi,
                             busy_res:   o_busy_res,
                             read_valid: o_read_valid,
                             read_data:  o_read_data,
                             write_done: o_write_done,
                             rejected:   o_rejected});
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task is entered and left just after a falling edge.
    // ------------------------------------------------------------------------

    // Offer one tick item; hold it until accepted, then log it with the
    // scoreboard. Valid is left high so the next item can follow directly.
    task automatic send_tick(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data,
                             logic miso);
        while (!steady_run && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_address    <= addr;
        i_write_data <= data;
        i_miso       <= miso;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_tick(cmd, addr, data, miso);
        @(negedge i_clk);
    endtask

    task automatic tick_run(int unsigned n, t_miso_mode mode);
        logic lvl;
        for (int unsigned k = 0; k < n; k++) begin
            case (mode)
                MISO_LOW:  lvl = 1'b0;
                MISO_HIGH: lvl = 1'b1;
                default:   lvl = 1'($urandom_range(1));
            endcase
            send_tick(CMD_TICK, 16'($urandom), 8'($urandom), lvl);
        end
    endtask

    // Tick until the running sequence is over. MISO low ends any status poll.
    task automatic settle();
        while (!sb.is_idle()) send_tick(CMD_TICK, 16'($urandom), 8'($urandom), 1'b0);
    endtask

    // Hold the input side until every result is back, then let the output
    // register drain, so that registers change only on a quiet block.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic program_timing(logic [7:0] half, logic [7:0] desel, bit with_spare);
        logic [CFG_IDX_W-1:0] idx_list[4];
        logic [7:0]           val_list[4];
        int unsigned          n;
        idx_list = '{CFG_HALF_PERIOD, CFG_DESELECT, CFG_SPARE_A, CFG_SPARE_B};
        val_list = '{half, desel, 8'($urandom), 8'($urandom)};
        n = with_spare ? 4 : 2;
        for (int unsigned k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_list[k];
            i_cfg_data  <= val_list[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_register(idx_list[k], val_list[k]);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Random stream: mostly well-formed requests on an idle block followed
    // by ticks with random MISO, plus refused requests and spare commands.
    task automatic random_ticks(int unsigned n);
        int unsigned roll;
        logic [1:0]  cmd;
        for (int unsigned k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if ((sb.is_idle() && roll < 35) || roll < 5) begin
                cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
            end else if (roll < 9) begin
                cmd = CMD_SPARE;
            end else begin
                cmd = CMD_TICK;
            end
            send_tick(cmd, 16'($urandom), 8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] half;
        logic [7:0] desel;

        sb           = new();
        steady_run   = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_cmd        = CMD_TICK;
        i_address    = 16'd0;
        i_write_data = 8'd0;
        i_miso       = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_HALF_PERIOD;
        i_cfg_data   = 8'd0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed cases on the reset timing (one tick per half period).
        // Plain and spare ticks on an idle block.
        send_tick(CMD_TICK, 16'hFFFF, 8'hFF, 1'b1);
        send_tick(CMD_SPARE, 16'h0000, 8'h00, 1'b0);
        // Read from the top address with MISO high; refuse a write and a
        // read mid-frame, tick with the spare code as well.
        send_tick(CMD_READ, 16'hFFFF, 8'h00, 1'b1);
        tick_run(10, MISO_HIGH);
        send_tick(CMD_WRITE, 16'h1234, 8'h56, 1'b1);
        send_tick(CMD_SPARE, 16'hFFFF, 8'hFF, 1'b1);
        send_tick(CMD_READ, 16'h4321, 8'h65, 1'b1);
        tick_run(60, MISO_HIGH);
        settle();
        // Write to address zero; hold the in-progress bit set over several
        // polls and refuse a request while polling, then let it clear.
        send_tick(CMD_WRITE, 16'h0000, 8'hFF, 1'b1);
        tick_run(150, MISO_HIGH);
        send_tick(CMD_READ, 16'hFFFF, 8'hFF, 1'b1);
        tick_run(20, MISO_HIGH);
        settle();

        // Zero in both registers acts as one; also poke the spare indexes.
        quiesce();
        program_timing(8'd0, 8'd0, 1'b1);
        send_tick(CMD_READ, 16'h00FF, 8'h00, 1'b0);
        tick_run(70, MISO_RANDOM);
        settle();

        // Longest deselect time: a read with alternating address bits, then
        // the full 255-tick gap before the block goes idle.
        quiesce();
        program_timing(8'd1, 8'd255, 1'b1);
        send_tick(CMD_READ, 16'hA5C3, 8'h00, 1'b0);
        tick_run(20, MISO_RANDOM);
        settle();

        // Random streams under fast timing settings; the second runs with no
        // idling at all.
        for (int unsigned p = 0; p < 2; p++) begin
            half  = ($urandom_range(3) == 0) ? 8'd0 : 8'd1;
            desel = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
            quiesce();
            program_timing(half, desel, p == 0);
            steady_run = (p == 1);
            random_ticks(50);
            settle();
            steady_run = 1'b0;
        end

        // Drain: wait for every outstanding result, then for the output
        // register to go quiet.
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Covered %0d tick items: %0d bytes read, %0d writes confirmed by poll,",
                 sb.items, sb.reads_done, sb.writes_done);
        $display("%0d requests refused while busy; deselect times from zero up to 255 ticks.",
                 sb.refusals);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
